// ===== rtl/core/itp_pkg.sv =====
// Shared types, operator codes and character helpers for the infix-to-postfix converter.
// Depends on nothing; used by every module in rtl/core.
package itp_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 3;

    // Operator codes held in the stack cells
    localparam logic [CODE_W-1:0] OP_NONE = 3'd0;
    localparam logic [CODE_W-1:0] OP_OPEN = 3'd1;
    localparam logic [CODE_W-1:0] OP_ADD  = 3'd2;
    localparam logic [CODE_W-1:0] OP_SUB  = 3'd3;
    localparam logic [CODE_W-1:0] OP_MUL  = 3'd4;
    localparam logic [CODE_W-1:0] OP_DIV  = 3'd5;
    localparam logic [CODE_W-1:0] OP_POW  = 3'd6;

    localparam logic [SYM_W-1:0] CH_END   = 8'h00;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_POW   = 8'h5E;

    // Shift command for the cell chain; code is what enters the top cell on a push
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CODE_W-1:0] code;
    } stack_cmd_t;

    function automatic logic is_operand(input logic [SYM_W-1:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
               (ch >= 8'h30 && ch <= 8'h39);
    endfunction

    function automatic logic [CODE_W-1:0] classify(input logic [SYM_W-1:0] ch);
        logic [CODE_W-1:0] c;
        case (ch)
            CH_OPEN: c = OP_OPEN;
            CH_ADD:  c = OP_ADD;
            CH_SUB:  c = OP_SUB;
            CH_MUL:  c = OP_MUL;
            CH_DIV:  c = OP_DIV;
            CH_POW:  c = OP_POW;
            default: c = OP_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] op_char(input logic [CODE_W-1:0] code);
        logic [SYM_W-1:0] c;
        case (code)
            OP_OPEN: c = CH_OPEN;
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_POW:  c = CH_POW;
            default: c = CH_END;
        endcase
        return c;
    endfunction

    // Incoming precedence; '^' sits above its own stacked value for right association
    function automatic logic [2:0] prec_in(input logic [CODE_W-1:0] code);
        logic [2:0] p;
        case (code)
            OP_POW:         p = 3'd4;
            OP_MUL, OP_DIV: p = 3'd2;
            default:        p = 3'd1;
        endcase
        return p;
    endfunction

    function automatic logic [2:0] prec_top(input logic [CODE_W-1:0] code);
        logic [2:0] p;
        case (code)
            OP_POW:         p = 3'd3;
            OP_MUL, OP_DIV: p = 3'd2;
            OP_ADD, OP_SUB: p = 3'd1;
            default:        p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/core/infix_to_postfix_converter_top.sv =====
// Infix-to-postfix converter top level: input decode, pop sequencer and output register.
// An operand is registered in the output register and appears on the output in the cycle after it is taken.
// Throughput: one item per cycle for operands, '(' and spaces while the output register is free;
// an operator or end code pops entries from the cell chain one at a time, then pushes or sends its marker,
// and no new symbol is taken meanwhile; ')' pops entries until it meets a '(' or the stack runs empty.
// Reset: aresetn (synchronous, active low) empties stack and output register; cells keep data.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] symbol
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_symbol
    output logic       m_tlast,    // expr_end
    output logic [0:0] m_tuser     // [0] overflow
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_OPER  = 4'b0010,
        ST_CLOSE = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [itp_pkg::CODE_W-1:0] pend_reg, pend_next;
    logic                       valid_reg, valid_next;
    logic [itp_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic                       end_reg, end_next;
    logic                       ovf_reg, ovf_next;

    itp_pkg::stack_cmd_t        cmd;
    logic [itp_pkg::CODE_W-1:0] top_code;
    logic                       out_free;
    logic                       nonempty;
    logic                       full;
    logic [itp_pkg::CODE_W-1:0] in_code;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .cmd      (cmd),
        .top_code (top_code)
    );

    assign out_free = !valid_reg || m_tready;
    assign nonempty = count_reg != '0;
    assign full     = count_reg == CNT_W'(STACK_DEPTH);
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_code  = itp_pkg::classify(s_tdata);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg;
        sym_next   = sym_reg;
        end_next   = end_reg;
        ovf_next   = ovf_reg;
        cmd.push   = 1'b0;
        cmd.pop    = 1'b0;
        cmd.code   = pend_reg;

        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (itp_pkg::is_operand(s_tdata)) begin
                        valid_next = 1'b1;
                        sym_next   = s_tdata;
                        end_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end else if (s_tdata == itp_pkg::CH_END) begin
                        state_next = ST_FLUSH;
                    end else if (s_tdata == itp_pkg::CH_CLOSE) begin
                        state_next = ST_CLOSE;
                    end else if (in_code == itp_pkg::OP_OPEN) begin
                        if (full) begin
                            valid_next = 1'b1;
                            sym_next   = itp_pkg::CH_END;
                            end_next   = 1'b0;
                            ovf_next   = 1'b1;
                        end else begin
                            cmd.push   = 1'b1;
                            cmd.code   = itp_pkg::OP_OPEN;
                            count_next = count_reg + 1'b1;
                        end
                    end else if (in_code != itp_pkg::OP_NONE) begin
                        pend_next  = in_code;
                        state_next = ST_OPER;
                    end
                end
            end
            ST_OPER: begin
                if (nonempty &&
                    itp_pkg::prec_in(pend_reg) <= itp_pkg::prec_top(top_code)) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        sym_next   = itp_pkg::op_char(top_code);
                        end_next   = 1'b0;
                        ovf_next   = 1'b0;
                        cmd.pop    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end else if (full) begin
                    if (out_free) begin
                        valid_next = 1'b1;
                        sym_next   = itp_pkg::CH_END;
                        end_next   = 1'b0;
                        ovf_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.push   = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE: begin
                if (!nonempty) begin
                    state_next = ST_IDLE;
                end else if (top_code == itp_pkg::OP_OPEN) begin
                    cmd.pop    = 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    valid_next = 1'b1;
                    sym_next   = itp_pkg::op_char(top_code);
                    end_next   = 1'b0;
                    ovf_next   = 1'b0;
                    cmd.pop    = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            ST_FLUSH: begin
                if (nonempty) begin
                    // held '(' are dropped silently
                    if (top_code == itp_pkg::OP_OPEN) begin
                        cmd.pop    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end else if (out_free) begin
                        valid_next = 1'b1;
                        sym_next   = itp_pkg::op_char(top_code);
                        end_next   = 1'b0;
                        ovf_next   = 1'b0;
                        cmd.pop    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end else if (out_free) begin
                    valid_next = 1'b1;
                    sym_next   = itp_pkg::CH_END;
                    end_next   = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        sym_reg  <= sym_next;
        end_reg  <= end_next;
        ovf_reg  <= ovf_next;
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = sym_reg;
    assign m_tlast    = end_reg;
    assign m_tuser[0] = ovf_reg;

endmodule

// ===== rtl/core/itp_cell.sv =====
// One stack cell: holds a single operator code, shifts towards the top or the bottom.
// Depends on itp_pkg.
module itp_cell (
    input  logic                      aclk,
    input  itp_pkg::stack_cmd_t       cmd,
    input  logic [itp_pkg::CODE_W-1:0] from_above,   // neighbour nearer the top
    input  logic [itp_pkg::CODE_W-1:0] from_below,   // neighbour nearer the bottom
    output logic [itp_pkg::CODE_W-1:0] code
);

    logic [itp_pkg::CODE_W-1:0] code_reg;
    logic [itp_pkg::CODE_W-1:0] code_next;

    always_comb begin
        code_next = code_reg;
        if (cmd.push) begin
            code_next = from_above;
        end else if (cmd.pop) begin
            code_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

// ===== rtl/core/itp_stack.sv =====
// Operator stack built as a chain of itp_cell; cell 0 is the top of stack.
// Depends on itp_pkg and itp_cell.
module itp_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                       aclk,
    input  itp_pkg::stack_cmd_t        cmd,
    output logic [itp_pkg::CODE_W-1:0] top_code
);

    logic [itp_pkg::CODE_W-1:0] cells [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [itp_pkg::CODE_W-1:0] above;
        logic [itp_pkg::CODE_W-1:0] below;

        if (i == 0) begin : g_top
            assign above = cmd.code;
        end else begin : g_mid
            assign above = cells[i-1];
        end

        // bottom cell refills with its own value; it lies beyond the count then
        if (i == STACK_DEPTH - 1) begin : g_bot
            assign below = cells[i];
        end else begin : g_up
            assign below = cells[i+1];
        end

        itp_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .code       (cells[i])
        );
    end

    assign top_code = cells[0];

endmodule

// ===== dv/postfix_scoreboard_pkg.sv =====
// Scoreboard for the infix-to-postfix converter: shunting-yard predictor and result checker.
// Depends on itp_pkg for operator codes and character constants.
package postfix_scoreboard_pkg;

    localparam int OP_STACK_DEPTH = 32;

    typedef struct packed {
        logic [itp_pkg::SYM_W-1:0] symbol;
        logic                      last;
        logic                      overflow;
    } postfix_item_t;

    class postfix_scoreboard;

        logic [itp_pkg::CODE_W-1:0] held_ops [OP_STACK_DEPTH];
        int                         held;
        postfix_item_t              pending [$];
        int                         errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        local function logic [itp_pkg::CODE_W-1:0] code_of(
            input logic [itp_pkg::SYM_W-1:0] sym);
            case (sym)
                itp_pkg::CH_OPEN: return itp_pkg::OP_OPEN;
                itp_pkg::CH_ADD:  return itp_pkg::OP_ADD;
                itp_pkg::CH_SUB:  return itp_pkg::OP_SUB;
                itp_pkg::CH_MUL:  return itp_pkg::OP_MUL;
                itp_pkg::CH_DIV:  return itp_pkg::OP_DIV;
                itp_pkg::CH_POW:  return itp_pkg::OP_POW;
                default:          return itp_pkg::OP_NONE;
            endcase
        endfunction

        local function logic [itp_pkg::SYM_W-1:0] char_of(
            input logic [itp_pkg::CODE_W-1:0] code);
            case (code)
                itp_pkg::OP_ADD:  return itp_pkg::CH_ADD;
                itp_pkg::OP_SUB:  return itp_pkg::CH_SUB;
                itp_pkg::OP_MUL:  return itp_pkg::CH_MUL;
                itp_pkg::OP_DIV:  return itp_pkg::CH_DIV;
                itp_pkg::OP_POW:  return itp_pkg::CH_POW;
                default:          return itp_pkg::CH_END;
            endcase
        endfunction

        // '^' arriving outranks a stacked '^', which gives right association
        local function int incoming_rank(input logic [itp_pkg::CODE_W-1:0] code);
            if (code == itp_pkg::OP_POW) return 4;
            if (code == itp_pkg::OP_MUL || code == itp_pkg::OP_DIV) return 2;
            return 1;
        endfunction

        local function int stacked_rank(input logic [itp_pkg::CODE_W-1:0] code);
            if (code == itp_pkg::OP_POW) return 3;
            if (code == itp_pkg::OP_MUL || code == itp_pkg::OP_DIV) return 2;
            if (code == itp_pkg::OP_ADD || code == itp_pkg::OP_SUB) return 1;
            return 0;
        endfunction

        local function void expect_item(input logic [itp_pkg::SYM_W-1:0] sym,
                                        input logic last, input logic ovf);
            postfix_item_t it;
            it.symbol   = sym;
            it.last     = last;
            it.overflow = ovf;
            pending = {pending, it};
        endfunction

        function void note_input(input logic [itp_pkg::SYM_W-1:0] sym);
            logic [itp_pkg::CODE_W-1:0] code;
            if (sym == itp_pkg::CH_SPACE)
                return;
            if ((sym >= "A" && sym <= "Z") || (sym >= "a" && sym <= "z") ||
                (sym >= "0" && sym <= "9")) begin
                expect_item(sym, 1'b0, 1'b0);
                return;
            end
            if (sym == itp_pkg::CH_END) begin
                // held '(' are dropped silently
                while (held > 0) begin
                    held--;
                    if (held_ops[held] != itp_pkg::OP_OPEN)
                        expect_item(char_of(held_ops[held]), 1'b0, 1'b0);
                end
                expect_item(itp_pkg::CH_END, 1'b1, 1'b0);
                return;
            end
            if (sym == itp_pkg::CH_CLOSE) begin
                while (held > 0) begin
                    held--;
                    if (held_ops[held] == itp_pkg::OP_OPEN)
                        break;
                    expect_item(char_of(held_ops[held]), 1'b0, 1'b0);
                end
                return;
            end
            code = code_of(sym);
            if (code == itp_pkg::OP_NONE)
                return;
            if (code != itp_pkg::OP_OPEN) begin
                while (held > 0 && incoming_rank(code) <= stacked_rank(held_ops[held-1])) begin
                    expect_item(char_of(held_ops[held-1]), 1'b0, 1'b0);
                    held--;
                end
            end
            if (held >= OP_STACK_DEPTH)
                expect_item(itp_pkg::CH_END, 1'b0, 1'b1);
            else begin
                held_ops[held] = code;
                held++;
            end
        endfunction

        function void check_result(input logic [itp_pkg::SYM_W-1:0] sym, input logic last,
                                   input logic ovf);
            postfix_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item sym %02h last %0b ovf %0b",
                         $time, sym, last, ovf);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.symbol !== sym) begin
                $display("%0t: out_symbol expected %02h actual %02h", $time, want.symbol, sym);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: expr_end expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
            if (want.overflow !== ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, want.overflow, ovf);
                errors++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb.sv =====
// Testbench top for infix_to_postfix_converter_top: directed and random expression streams,
// random idling on both sides, and a long output hold. Depends on itp_pkg and postfix_scoreboard_pkg.
module tb;

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 2 * postfix_scoreboard_pkg::OP_STACK_DEPTH + 16;
    localparam int PHASE_ITEMS = 84;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    postfix_scoreboard_pkg::postfix_scoreboard board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int hold_asked     = 0;
    int hold_given     = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH (postfix_scoreboard_pkg::OP_STACK_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_given != hold_asked) begin
            hold_given++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast, m_tuser[0]);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL infix_to_postfix_converter_top");
            $finish;
        end
    end

    // entered and left at a falling edge
    task automatic send_symbol(input logic [7:0] sym);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        do @(posedge aclk); while (!s_tready);
        board.note_input(sym);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 4))
            0:       return itp_pkg::CH_ADD;
            1:       return itp_pkg::CH_SUB;
            2:       return itp_pkg::CH_MUL;
            3:       return itp_pkg::CH_DIV;
            default: return itp_pkg::CH_POW;
        endcase
    endfunction

    task automatic send_expression();
        int terms;
        int opened;
        terms  = $urandom_range(1, 7);
        opened = 0;
        for (int t = 0; t < terms; t++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_symbol(itp_pkg::CH_OPEN);
                opened++;
            end
            if ($urandom_range(0, 5) == 0)
                send_symbol(itp_pkg::CH_SPACE);
            send_symbol(pick_operand());
            if (opened > 0 && $urandom_range(0, 2) == 0) begin
                send_symbol(itp_pkg::CH_CLOSE);
                opened--;
            end
            if (t < terms - 1)
                send_symbol(pick_operator());
            if ($urandom_range(0, 19) == 0)
                send_symbol(8'($urandom_range(0, 255)));
        end
        // usually close what is open; the rest is left for the end code to drop
        while (opened > 0 && $urandom_range(0, 4) != 0) begin
            send_symbol(itp_pkg::CH_CLOSE);
            opened--;
        end
        if ($urandom_range(0, 9) == 0)
            send_symbol(itp_pkg::CH_CLOSE);
        send_symbol(itp_pkg::CH_END);
    endtask

    // nesting or a '^' chain that comes near, and often reaches or passes, a full stack
    task automatic send_deep_run();
        int depth;
        int closes;
        depth = $urandom_range(30, 36);
        if ($urandom_range(0, 1) == 0) begin
            for (int i = 0; i < depth; i++)
                send_symbol(itp_pkg::CH_OPEN);
            send_symbol(pick_operand());
            send_symbol(pick_operator());
            send_symbol(pick_operand());
            closes = $urandom_range(0, depth);
            for (int i = 0; i < closes; i++)
                send_symbol(itp_pkg::CH_CLOSE);
        end else begin
            send_symbol(pick_operand());
            for (int i = 0; i < depth; i++) begin
                send_symbol(itp_pkg::CH_POW);
                send_symbol(pick_operand());
            end
            send_symbol(pick_operator());
            send_symbol(pick_operand());
        end
        send_symbol(itp_pkg::CH_END);
    endtask

    initial begin
        string head;
        string tail;
        int    start;

        head = "(A+z)*0^9^Q/ b-(c";
        tail = "a-b)";
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: the operand range bounds A, z, 0 and 9, every operator, '^' chain,
        // a '(' left open at the end, ')' on an empty stack, an unknown code,
        // ')' with no '(' held, and an end code on an empty stack
        for (int i = 0; i < head.len(); i++)
            send_symbol(head[i]);
        send_symbol(itp_pkg::CH_END);
        send_symbol(itp_pkg::CH_CLOSE);
        send_symbol(8'hFF);
        for (int i = 0; i < tail.len(); i++)
            send_symbol(tail[i]);
        send_symbol(itp_pkg::CH_END);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            start = items_sent;
            if (phase == 0)
                hold_asked++;
            send_deep_run();
            while (items_sent - start < PHASE_ITEMS)
                send_expression();
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS infix_to_postfix_converter_top");
        else
            $display("FAIL infix_to_postfix_converter_top");
        $finish;
    end

endmodule
